### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; they expand to nothing for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// ante holds -> cons holds in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// ante holds -> cons holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### rtl/tsp_pkg.sv
// ---------------------------------------------------------------------------
// tsp_pkg
// Shared types and constants of the transport stream header parser.
// ---------------------------------------------------------------------------
package tsp_pkg;

   localparam int PID_W      = 13;
   localparam int CFG_PID_W  = 14;
   localparam int POS_W      = 9;   // payload offset, up to 5 + 255
   localparam int PCR_W      = 42;
   localparam int PCR_BASE_W = 33;
   localparam int PCR_EXT_W  = 9;
   localparam int PCR_SHIFT_W = 48;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [PID_W-1:0]     PAT_PID   = 13'h0000;
   localparam logic [PID_W-1:0]     SDT_PID   = 13'h0011;
   localparam logic [CFG_PID_W-1:0] PID_UNSET = 14'h3fff;

   localparam int PCR_FLAG_BIT  = 4;
   localparam int DISC_FLAG_BIT = 7;
   localparam logic [7:0]       PCR_MIN_ALEN = 8'd7;
   localparam logic [PCR_W-1:0] PCR_SCALE    = 42'd300;

   // byte offsets inside the packet
   localparam int ADAPT_LEN_BYTE   = 4;
   localparam int ADAPT_FLAGS_BYTE = 5;
   localparam int PCR_FIRST_BYTE   = 6;
   localparam int PCR_LAST_BYTE    = 11;
   localparam logic [POS_W-1:0] PAYLOAD_POS_PLAIN = 9'd4;
   localparam logic [POS_W-1:0] PAYLOAD_POS_ADAPT = 9'd5;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_SECTION = 2'd1,
      KIND_PES     = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      REG_PMT_PID   = 2'd0,
      REG_VIDEO_PID = 2'd1,
      REG_AUDIO_PID = 2'd2
   } csr_index_type;

   // captured packet, handed from front to back
   typedef struct packed {
      logic [PID_W-1:0]      pid;
      logic                  start;
      logic [1:0]            afc;
      logic [3:0]            cc;
      logic [7:0]            alen;
      logic [7:0]            aflags;
      logic [PCR_BASE_W-1:0] pcr_base;
      logic [PCR_EXT_W-1:0]  pcr_ext;
      logic [7:0]            pointer;
   } pkt_rec_type;

   typedef struct packed {
      logic [CFG_PID_W-1:0] pmt;
      logic [CFG_PID_W-1:0] video;
      logic [CFG_PID_W-1:0] audio;
   } pid_cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

### rtl/tsp_stream_if.sv
// ---------------------------------------------------------------------------
// tsp_req_if / tsp_rsp_if
// Byte input channel and summary output channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface tsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;

   modport source (output valid, output data_byte, output first_byte, input ready);
   modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface tsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [12:0] packet_pid;
   logic        unit_start;
   logic        adaptation_present;
   logic        payload_present;
   logic        discontinuity;
   logic [3:0]  continuity_count;
   logic [7:0]  adaptation_length;
   logic [41:0] clock_reference;
   logic        clock_valid;
   logic [1:0]  packet_kind;

   modport source (
      output valid, output packet_pid, output unit_start,
      output adaptation_present, output payload_present, output discontinuity,
      output continuity_count, output adaptation_length, output clock_reference,
      output clock_valid, output packet_kind, input ready
   );
   modport sink (
      input valid, input packet_pid, input unit_start,
      input adaptation_present, input payload_present, input discontinuity,
      input continuity_count, input adaptation_length, input clock_reference,
      input clock_valid, input packet_kind, output ready
   );
endinterface

### rtl/ts_packet_header_parser_unit.sv
// ---------------------------------------------------------------------------
// ts_packet_header_parser_unit
// Transport stream packet header parser: bytes in, one summary per packet.
// ---------------------------------------------------------------------------
//
//   channel   dir   beat                         handshake
//   req_chan  in    one packet byte + sync mark  valid/ready
//   rsp_chan  out   one packet summary           valid/ready
//   csr_*     in    PID register write/read      APB, pready tied high
//
// One byte is taken per cycle while req_chan.ready is high, back to back;
// the byte counter is the only per-byte loop. After the packet's last byte
// a summary passes through the record queue, then the classify/PCR-scale stage.
// req_chan.ready drops only while two summaries wait in the queue behind a
// stalled rsp_chan. Reset is synchronous and needs no clearing pass; PID
// registers come out of reset as -1 (unset).
//
`include "assert_macros.svh"

module ts_packet_header_parser_unit import tsp_pkg::*; #(
   parameter int PACKET_BYTES = 188
) (
   input  logic                  clock,
   input  logic                  reset,
   tsp_req_if.sink               req_chan,
   tsp_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   pid_cfg_type  cfg;
   q_status_type q_status;
   logic         push;
   logic         pop;
   pkt_rec_type  push_rec;
   pkt_rec_type  pop_rec;

   // PID registers, read live by the back end (the user must write them only while idle; not enforced)
   tsp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // byte counter, header/adaptation/PCR/pointer capture
   tsp_front #(.PACKET_BYTES(PACKET_BYTES)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_status (q_status),
      .push     (push),
      .push_rec (push_rec)
   );

   // decouples capture from a stalled result side
   tsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .pop_rec  (pop_rec),
      .q_status (q_status)
   );

   // classification, PCR base*300+ext, output register
   tsp_back #(.PACKET_BYTES(PACKET_BYTES)) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_status (q_status),
      .rec      (pop_rec),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   // a record is only pushed on an accepted beat, and lands in the queue
   `ASSERT_IMPLY(a_push_on_beat, clock, reset, push, req_chan.valid && req_chan.ready)
   `ASSERT_NEXT(a_push_lands, clock, reset, push, !q_status.empty)
   // PCR only with a long enough adaptation field
   `ASSERT_IMPLY(a_pcr_needs_adapt, clock, reset, rsp_chan.valid && rsp_chan.clock_valid,
                 rsp_chan.adaptation_present && rsp_chan.adaptation_length >= PCR_MIN_ALEN)
   // any classification needs a payload
   `ASSERT_IMPLY(a_kind_needs_payload, clock, reset,
                 rsp_chan.valid && rsp_chan.packet_kind != KIND_NONE, rsp_chan.payload_present)

endmodule

### rtl/tsp_csr.sv
// ---------------------------------------------------------------------------
// tsp_csr
// APB register file holding the program map, video and audio PIDs.
// ---------------------------------------------------------------------------
module tsp_csr import tsp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output pid_cfg_type           cfg
);

   logic [CFG_PID_W-1:0] pmt_ff, pmt_in;
   logic [CFG_PID_W-1:0] video_ff, video_in;
   logic [CFG_PID_W-1:0] audio_ff, audio_in;
   logic                 wr_en;
   csr_index_type        idx;

   assign wr_en  = psel && penable && pwrite;
   assign idx    = csr_index_type'(paddr[3:2]);
   assign pready = 1'b1;

   always_comb begin
      pmt_in   = pmt_ff;
      video_in = video_ff;
      audio_in = audio_ff;
      if (wr_en) begin
         unique case (idx)
            REG_PMT_PID:   pmt_in   = pwdata[CFG_PID_W-1:0];
            REG_VIDEO_PID: video_in = pwdata[CFG_PID_W-1:0];
            REG_AUDIO_PID: audio_in = pwdata[CFG_PID_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pmt_ff   <= PID_UNSET;
         video_ff <= PID_UNSET;
         audio_ff <= PID_UNSET;
      end else begin
         pmt_ff   <= pmt_in;
         video_ff <= video_in;
         audio_ff <= audio_in;
      end
   end

   // reads return the sign-extended register
   always_comb begin
      unique case (idx)
         REG_PMT_PID:   prdata = CSR_DATA_W'(signed'(pmt_ff));
         REG_VIDEO_PID: prdata = CSR_DATA_W'(signed'(video_ff));
         REG_AUDIO_PID: prdata = CSR_DATA_W'(signed'(audio_ff));
         default:       prdata = '0;
      endcase
   end

   assign cfg.pmt   = pmt_ff;
   assign cfg.video = video_ff;
   assign cfg.audio = audio_ff;

endmodule

### rtl/tsp_front.sv
// ---------------------------------------------------------------------------
// tsp_front
// Byte counter and header capture; pushes one record per complete packet.
// ---------------------------------------------------------------------------
module tsp_front import tsp_pkg::*; #(
   parameter int PACKET_BYTES = 188
) (
   input  logic         clock,
   input  logic         reset,
   tsp_req_if.sink      req_chan,
   input  q_status_type q_status,
   output logic         push,
   output pkt_rec_type  push_rec
);

   localparam int IDX_W = $clog2(PACKET_BYTES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PACKET_BYTES - 1);

   logic [IDX_W-1:0]       byte_index_ff, byte_index_in;
   logic                   in_packet_ff, in_packet_in;
   logic [7:0]             hdr1_ff, hdr1_in;
   logic [7:0]             hdr2_ff, hdr2_in;
   logic [7:0]             hdr3_ff, hdr3_in;
   logic [7:0]             alen_ff, alen_in;
   logic [7:0]             aflags_ff, aflags_in;
   logic [PCR_SHIFT_W-1:0] pcr_ff, pcr_in;
   logic [7:0]             ptr_ff, ptr_in;

   logic             accept;
   logic             active;
   logic             last;
   logic [IDX_W-1:0] idx;
   logic [POS_W-1:0] pos;

   assign req_chan.ready = !q_status.full;
   assign accept = req_chan.valid && req_chan.ready;
   assign active = accept && (req_chan.first_byte || in_packet_ff);
   assign idx    = req_chan.first_byte ? '0 : byte_index_ff;
   assign last   = (idx == LAST_IDX);

   always_comb begin
      hdr1_in   = hdr1_ff;
      hdr2_in   = hdr2_ff;
      hdr3_in   = hdr3_ff;
      alen_in   = alen_ff;
      aflags_in = aflags_ff;
      pcr_in    = pcr_ff;
      ptr_in    = ptr_ff;
      if (active) begin
         if (idx == IDX_W'(1)) hdr1_in = req_chan.data_byte;
         if (idx == IDX_W'(2)) hdr2_in = req_chan.data_byte;
         if (idx == IDX_W'(3)) hdr3_in = req_chan.data_byte;
         if (idx == IDX_W'(ADAPT_LEN_BYTE))   alen_in   = req_chan.data_byte;
         if (idx == IDX_W'(ADAPT_FLAGS_BYTE)) aflags_in = req_chan.data_byte;
         if (idx >= IDX_W'(PCR_FIRST_BYTE) && idx <= IDX_W'(PCR_LAST_BYTE))
            pcr_in = {pcr_ff[PCR_SHIFT_W-9:0], req_chan.data_byte};
      end
      // payload offset uses the length byte even when it arrives this beat
      pos = hdr3_in[5] ? (PAYLOAD_POS_ADAPT + POS_W'(alen_in)) : PAYLOAD_POS_PLAIN;
      if (active && POS_W'(idx) == pos)
         ptr_in = req_chan.data_byte;
   end

   always_comb begin
      byte_index_in = byte_index_ff;
      in_packet_in  = in_packet_ff;
      if (active) begin
         if (last) begin
            byte_index_in = '0;
            in_packet_in  = 1'b0;
         end else begin
            byte_index_in = idx + IDX_W'(1);
            in_packet_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         in_packet_ff  <= 1'b0;
         hdr1_ff       <= '0;
         hdr2_ff       <= '0;
         hdr3_ff       <= '0;
         alen_ff       <= '0;
         aflags_ff     <= '0;
         pcr_ff        <= '0;
         ptr_ff        <= '0;
      end else begin
         byte_index_ff <= byte_index_in;
         in_packet_ff  <= in_packet_in;
         hdr1_ff       <= hdr1_in;
         hdr2_ff       <= hdr2_in;
         hdr3_ff       <= hdr3_in;
         alen_ff       <= alen_in;
         aflags_ff     <= aflags_in;
         pcr_ff        <= pcr_in;
         ptr_ff        <= ptr_in;
      end
   end

   assign push = active && last;

   assign push_rec.pid      = {hdr1_in[4:0], hdr2_in};
   assign push_rec.start    = hdr1_in[6];
   assign push_rec.afc      = hdr3_in[5:4];
   assign push_rec.cc       = hdr3_in[3:0];
   assign push_rec.alen     = alen_in;
   assign push_rec.aflags   = aflags_in;
   assign push_rec.pcr_base = pcr_in[PCR_SHIFT_W-1:PCR_SHIFT_W-PCR_BASE_W];
   assign push_rec.pcr_ext  = pcr_in[PCR_EXT_W-1:0];
   assign push_rec.pointer  = ptr_in;

endmodule

### rtl/tsp_queue.sv
// ---------------------------------------------------------------------------
// tsp_queue
// Two-entry record queue between capture and classification.
// ---------------------------------------------------------------------------
module tsp_queue import tsp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  pkt_rec_type  push_rec,
   input  logic         pop,
   output pkt_rec_type  pop_rec,
   output q_status_type q_status
);

   pkt_rec_type mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= push_rec;
   end

   assign pop_rec        = mem_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == 2'd2);
   assign q_status.empty = (count_ff == 2'd0);

endmodule

### rtl/tsp_back.sv
// ---------------------------------------------------------------------------
// tsp_back
// Classifies a captured packet, scales the PCR and holds the summary beat.
// ---------------------------------------------------------------------------
module tsp_back import tsp_pkg::*; #(
   parameter int PACKET_BYTES = 188
) (
   input  logic         clock,
   input  logic         reset,
   input  pid_cfg_type  cfg,
   input  q_status_type q_status,
   input  pkt_rec_type  rec,
   output logic         pop,
   tsp_rsp_if.source    rsp_chan
);

   localparam logic [POS_W-1:0] PKT_BYTES = POS_W'(PACKET_BYTES);
   localparam logic [POS_W-1:0] PKT_LAST  = POS_W'(PACKET_BYTES - 1);

   logic             valid_ff, valid_in;
   logic [PID_W-1:0] pid_ff;
   logic             start_ff, has_ad_ff, has_pl_ff, disc_ff, cvalid_ff;
   logic [3:0]       cc_ff;
   logic [7:0]       alen_ff;
   logic [PCR_W-1:0] pcr_ff;
   kind_type         kind_ff;

   logic             load;
   logic             afc_ok;
   logic             has_ad, has_pl, disc, cvalid;
   logic [3:0]       cc;
   logic [7:0]       alen;
   logic [PCR_W-1:0] pcr_base_w;
   logic [PCR_W-1:0] pcr_prod;
   logic [PCR_W-1:0] pcr;
   logic [POS_W-1:0] pos;
   logic [POS_W-1:0] bound;
   logic             psi, pes;
   kind_type         kind;

   assign load = !q_status.empty && (!valid_ff || rsp_chan.ready);
   assign pop  = load;

   always_comb begin
      afc_ok   = (rec.afc != 2'b00);
      has_ad   = afc_ok && rec.afc[1];
      has_pl   = afc_ok && rec.afc[0];
      cc       = afc_ok ? rec.cc : 4'd0;
      alen     = has_ad ? rec.alen : 8'd0;
      disc     = has_ad && (rec.alen != 8'd0) && rec.aflags[DISC_FLAG_BIT];
      cvalid   = has_ad && (rec.alen >= PCR_MIN_ALEN) && rec.aflags[PCR_FLAG_BIT];
      // base * 300 as 256 + 32 + 8 + 4
      pcr_base_w = PCR_W'(rec.pcr_base);
      pcr_prod   = (pcr_base_w << 8) + (pcr_base_w << 5) + (pcr_base_w << 3) +
                   (pcr_base_w << 2);
      pcr      = cvalid ? (pcr_prod + PCR_W'(rec.pcr_ext)) : '0;

      pos   = rec.afc[1] ? (PAYLOAD_POS_ADAPT + POS_W'(rec.alen)) : PAYLOAD_POS_PLAIN;
      bound = PKT_LAST - pos;
      psi   = (rec.pid == PAT_PID) || (rec.pid == SDT_PID) ||
              (!cfg.pmt[CFG_PID_W-1] && cfg.pmt[PID_W-1:0] == rec.pid);
      pes   = (!cfg.video[CFG_PID_W-1] && cfg.video[PID_W-1:0] == rec.pid) ||
              (!cfg.audio[CFG_PID_W-1] && cfg.audio[PID_W-1:0] == rec.pid);

      kind = KIND_NONE;
      if (has_pl && pos < PKT_BYTES) begin
         if (psi) begin
            if (POS_W'(rec.pointer) <= bound)
               kind = KIND_SECTION;
         end else if (pes) begin
            kind = KIND_PES;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load)
         valid_in = 1'b1;
      else if (rsp_chan.ready)
         valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pid_ff    <= rec.pid;
         start_ff  <= rec.start;
         has_ad_ff <= has_ad;
         has_pl_ff <= has_pl;
         disc_ff   <= disc;
         cc_ff     <= cc;
         alen_ff   <= alen;
         pcr_ff    <= pcr;
         cvalid_ff <= cvalid;
         kind_ff   <= kind;
      end
   end

   assign rsp_chan.valid              = valid_ff;
   assign rsp_chan.packet_pid         = pid_ff;
   assign rsp_chan.unit_start         = start_ff;
   assign rsp_chan.adaptation_present = has_ad_ff;
   assign rsp_chan.payload_present    = has_pl_ff;
   assign rsp_chan.discontinuity      = disc_ff;
   assign rsp_chan.continuity_count   = cc_ff;
   assign rsp_chan.adaptation_length  = alen_ff;
   assign rsp_chan.clock_reference    = pcr_ff;
   assign rsp_chan.clock_valid        = cvalid_ff;
   assign rsp_chan.packet_kind        = kind_ff;

endmodule
